@@ hw/rtl/ael_pkg.sv @@
// Shared types and constants for the antenna element location block.
// Holds the register map, the configuration bundle and the fixed field widths.
// No dependencies.
`default_nettype none

package ael_pkg;

  localparam int IDX_W      = 13;
  localparam int SIDE_REG_W = 7;
  localparam int COEF_W     = 16;
  localparam int POS_W      = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int POS_MAX = 2 ** (POS_W - 1) - 1;
  localparam int POS_MIN = -(2 ** (POS_W - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_ROWS       = 3'd0,
    REG_NUM_COLUMNS    = 3'd1,
    REG_DUAL_POLARIZED = 3'd2,
    REG_COLUMN_TO_X    = 3'd3,
    REG_COLUMN_TO_Y    = 3'd4,
    REG_ROW_TO_X       = 3'd5,
    REG_ROW_TO_Y       = 3'd6,
    REG_ROW_TO_Z       = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [SIDE_REG_W-1:0]    num_rows;
    logic [SIDE_REG_W-1:0]    num_columns;
    logic                     dual_polarized;
    logic signed [COEF_W-1:0] column_to_x;
    logic signed [COEF_W-1:0] column_to_y;
    logic signed [COEF_W-1:0] row_to_x;
    logic signed [COEF_W-1:0] row_to_y;
    logic signed [COEF_W-1:0] row_to_z;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    num_rows:       7'd4,
    num_columns:    7'd4,
    dual_polarized: 1'b0,
    column_to_x:    16'sd0,
    column_to_y:    16'sd1024,
    row_to_x:       16'sd0,
    row_to_y:       16'sd0,
    row_to_z:       16'sd1024
  };

endpackage

`default_nettype wire

@@ hw/rtl/ael_cfg.sv @@
// Configuration register file of the antenna element location block.
// Decodes register writes into the cfg_t bundle; depends on ael_pkg.
`default_nettype none

module ael_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ael_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ael_pkg::CFG_DATA_W-1:0] cfg_data,
  output ael_pkg::cfg_t                       cfg
);
  import ael_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NUM_ROWS:       cfg.num_rows       <= cfg_data[SIDE_REG_W-1:0];
        REG_NUM_COLUMNS:    cfg.num_columns    <= cfg_data[SIDE_REG_W-1:0];
        REG_DUAL_POLARIZED: cfg.dual_polarized <= cfg_data[0];
        REG_COLUMN_TO_X:    cfg.column_to_x    <= signed'(cfg_data[COEF_W-1:0]);
        REG_COLUMN_TO_Y:    cfg.column_to_y    <= signed'(cfg_data[COEF_W-1:0]);
        REG_ROW_TO_X:       cfg.row_to_x       <= signed'(cfg_data[COEF_W-1:0]);
        REG_ROW_TO_Y:       cfg.row_to_y       <= signed'(cfg_data[COEF_W-1:0]);
        REG_ROW_TO_Z:       cfg.row_to_z       <= signed'(cfg_data[COEF_W-1:0]);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ael_front.sv @@
// Input stage: range check against the element count and polarization fold.
// Also keeps the clamped column count for the divider; depends on ael_pkg.
`default_nettype none

module ael_front #(
  parameter int MAX_SIDE = 64,
  parameter int SW       = 7
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ael_pkg::cfg_t               cfg,
  input  wire logic                        up_valid,
  output logic                             up_ready,
  input  wire logic [ael_pkg::IDX_W-1:0]   element_index,
  output logic                             dn_valid,
  input  wire logic                        dn_ready,
  output logic [ael_pkg::IDX_W-1:0]        dn_rem,
  output logic                             dn_pol,
  output logic                             dn_err,
  output logic [SW-1:0]                    cols
);
  import ael_pkg::*;

  localparam int LW = (2 * SW + 1 > IDX_W) ? 2 * SW + 1 : IDX_W;

  logic [SW-1:0]   rows_next;
  logic [SW-1:0]   cols_next;
  logic [2*SW-1:0] plane;
  logic [LW-1:0]   count;
  logic [LW-1:0]   idx_ext;
  logic [LW-1:0]   plane_ext;
  logic [LW-1:0]   diff;
  logic            err_next;
  logic            upper;

  always_comb begin
    rows_next = (int'(cfg.num_rows) > MAX_SIDE) ? SW'(MAX_SIDE) : cfg.num_rows[SW-1:0];
    cols_next = (int'(cfg.num_columns) > MAX_SIDE) ? SW'(MAX_SIDE) : cfg.num_columns[SW-1:0];
    plane     = (2 * SW)'(rows_next) * (2 * SW)'(cols_next);
  end

  // The divider reads the column count only after a word has been registered by this stage.
  always_ff @(posedge clk) begin
    cols <= cols_next;
  end

  always_comb begin
    idx_ext   = LW'(element_index);
    plane_ext = LW'(plane);
    count     = cfg.dual_polarized ? (plane_ext << 1) : plane_ext;
    err_next  = idx_ext >= count;
    diff      = idx_ext - plane_ext;
    upper     = cfg.dual_polarized && (idx_ext >= plane_ext);
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_rem <= upper ? diff[IDX_W-1:0] : element_index;
      dn_pol <= upper && !err_next;
      dn_err <= err_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ael_div_step.sv @@
// One restoring division stage: decides one row bit of index / columns.
// Chained once per quotient bit by the top level; depends on ael_pkg.
`default_nettype none

module ael_div_step #(
  parameter int SW  = 7,
  parameter int QW  = 6,
  parameter int BIT = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [SW-1:0]             cols,
  input  wire logic                      up_valid,
  output logic                           up_ready,
  input  wire logic [ael_pkg::IDX_W-1:0] up_rem,
  input  wire logic [QW-1:0]             up_quot,
  input  wire logic                      up_pol,
  input  wire logic                      up_err,
  output logic                           dn_valid,
  input  wire logic                      dn_ready,
  output logic [ael_pkg::IDX_W-1:0]      dn_rem,
  output logic [QW-1:0]                  dn_quot,
  output logic                           dn_pol,
  output logic                           dn_err
);
  import ael_pkg::*;

  localparam int DW = (IDX_W > SW + QW) ? IDX_W : SW + QW;

  logic [DW-1:0]    rem_ext;
  logic [DW-1:0]    dvs;
  logic             ge;
  logic [IDX_W-1:0] rem_next;
  logic [QW-1:0]    quot_next;

  always_comb begin
    rem_ext        = DW'(up_rem);
    dvs            = DW'(cols) << BIT;
    ge             = rem_ext >= dvs;
    rem_next       = ge ? IDX_W'(rem_ext - dvs) : up_rem;
    quot_next      = up_quot;
    quot_next[BIT] = ge;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_rem  <= rem_next;
      dn_quot <= quot_next;
      dn_pol  <= up_pol;
      dn_err  <= up_err;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ael_mac.sv @@
// Coordinate stages: five coefficient products, then sums with saturation.
// Out-of-range words give zero coordinates; depends on ael_pkg.
`default_nettype none

module ael_mac #(
  parameter int SW = 7,
  parameter int QW = 6
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ael_pkg::cfg_t                     cfg,
  input  wire logic                              up_valid,
  output logic                                   up_ready,
  input  wire logic [SW-1:0]                     up_col,
  input  wire logic [QW-1:0]                     up_row,
  input  wire logic                              up_pol,
  input  wire logic                              up_err,
  output logic                                   dn_valid,
  input  wire logic                              dn_ready,
  output logic signed [ael_pkg::POS_W-1:0]       pos_x,
  output logic signed [ael_pkg::POS_W-1:0]       pos_y,
  output logic signed [ael_pkg::POS_W-1:0]       pos_z,
  output logic                                   polarization,
  output logic                                   index_error
);
  import ael_pkg::*;

  localparam int MW   = (SW > QW) ? SW : QW;
  localparam int PRW  = COEF_W + MW + 1;
  localparam int SUMW = (PRW + 1 > POS_W + 1) ? PRW + 1 : POS_W + 1;
  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(POS_MAX);
  localparam logic signed [SUMW-1:0] SAT_LO = SUMW'(POS_MIN);

  logic signed [MW:0]      col_s;
  logic signed [MW:0]      row_s;
  logic                    p_valid;
  logic                    p_ready;
  logic signed [PRW-1:0]   cx;
  logic signed [PRW-1:0]   cy;
  logic signed [PRW-1:0]   rx;
  logic signed [PRW-1:0]   ry;
  logic signed [PRW-1:0]   rz;
  logic                    p_pol;
  logic                    p_err;
  logic signed [SUMW-1:0]  sx;
  logic signed [SUMW-1:0]  sy;
  logic signed [SUMW-1:0]  sz;
  logic signed [POS_W-1:0] x_next;
  logic signed [POS_W-1:0] y_next;
  logic signed [POS_W-1:0] z_next;

  always_comb begin
    col_s = signed'((MW + 1)'(up_col));
    row_s = signed'((MW + 1)'(up_row));
  end

  assign up_ready = !p_valid || p_ready;
  assign p_ready  = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid  <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (up_ready) begin
        p_valid <= up_valid;
      end
      if (p_ready) begin
        dn_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      cx    <= PRW'(cfg.column_to_x) * PRW'(col_s);
      cy    <= PRW'(cfg.column_to_y) * PRW'(col_s);
      rx    <= PRW'(cfg.row_to_x) * PRW'(row_s);
      ry    <= PRW'(cfg.row_to_y) * PRW'(row_s);
      rz    <= PRW'(cfg.row_to_z) * PRW'(row_s);
      p_pol <= up_pol;
      p_err <= up_err;
    end
  end

  always_comb begin
    sx = SUMW'(cx) + SUMW'(rx);
    sy = SUMW'(cy) + SUMW'(ry);
    sz = SUMW'(rz);
    x_next = (sx > SAT_HI) ? SAT_HI[POS_W-1:0] :
             (sx < SAT_LO) ? SAT_LO[POS_W-1:0] : sx[POS_W-1:0];
    y_next = (sy > SAT_HI) ? SAT_HI[POS_W-1:0] :
             (sy < SAT_LO) ? SAT_LO[POS_W-1:0] : sy[POS_W-1:0];
    z_next = (sz > SAT_HI) ? SAT_HI[POS_W-1:0] :
             (sz < SAT_LO) ? SAT_LO[POS_W-1:0] : sz[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (p_ready && p_valid) begin
      pos_x        <= p_err ? '0 : x_next;
      pos_y        <= p_err ? '0 : y_next;
      pos_z        <= p_err ? '0 : z_next;
      polarization <= p_pol;
      index_error  <= p_err;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/antenna_element_location.sv @@
// Antenna element location, top level.
// Depends on ael_pkg, ael_cfg, ael_front, ael_div_step and ael_mac.
//
// Each input word is an element index; each output word carries the element's
// global x, y and z position in Q.11 wavelengths, its polarization and an
// index error flag. Both channels use valid and stall: a word moves at a
// clock edge where valid is high and stall is low.
// The configuration channel writes one register per cfg_valid cycle; it is
// always ready. Registers must be changed by the user only while no word is
// in flight; the block does not enforce this. The pipeline has a stage for
// the range check and polarization fold, a stage for each row bit of the
// restoring divider that splits the index into row and column, a stage for
// the coefficient products and one for the sums and saturation.
// Throughput is one word per cycle while the receiver does not stall. When the
// receiver stalls, the output word holds and upstream stages keep filling any
// empty slots before in_stall rises. Synchronous reset empties the pipeline and
// loads the register defaults: a 4 by 4 single-polarized array with
// half-wavelength spacing, columns along y and rows along z.
`default_nettype none

module antenna_element_location #(
  parameter int MAX_SIDE = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [ael_pkg::IDX_W-1:0]         element_index,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [ael_pkg::POS_W-1:0]       pos_x,
  output logic signed [ael_pkg::POS_W-1:0]       pos_y,
  output logic signed [ael_pkg::POS_W-1:0]       pos_z,
  output logic                                   polarization,
  output logic                                   index_error,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ael_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ael_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ael_pkg::*;

  localparam int SW = (MAX_SIDE >= 127) ? SIDE_REG_W : $clog2(MAX_SIDE + 1);
  localparam int QW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

  cfg_t             cfg;
  logic [SW-1:0]    cols;
  logic             front_ready;
  logic             mac_ready;
  logic             stg_valid [0:QW];
  logic             stg_ready [0:QW];
  logic [IDX_W-1:0] stg_rem   [0:QW];
  logic [QW-1:0]    stg_quot  [0:QW];
  logic             stg_pol   [0:QW];
  logic             stg_err   [0:QW];

  ael_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ael_front #(
    .MAX_SIDE (MAX_SIDE),
    .SW       (SW)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .up_valid      (in_valid),
    .up_ready      (front_ready),
    .element_index (element_index),
    .dn_valid      (stg_valid[0]),
    .dn_ready      (stg_ready[0]),
    .dn_rem        (stg_rem[0]),
    .dn_pol        (stg_pol[0]),
    .dn_err        (stg_err[0]),
    .cols          (cols)
  );

  assign in_stall    = !front_ready;
  assign stg_quot[0] = '0;

  for (genvar j = 0; j < QW; j++) begin : g_div
    ael_div_step #(
      .SW  (SW),
      .QW  (QW),
      .BIT (QW - 1 - j)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .cols     (cols),
      .up_valid (stg_valid[j]),
      .up_ready (stg_ready[j]),
      .up_rem   (stg_rem[j]),
      .up_quot  (stg_quot[j]),
      .up_pol   (stg_pol[j]),
      .up_err   (stg_err[j]),
      .dn_valid (stg_valid[j+1]),
      .dn_ready (stg_ready[j+1]),
      .dn_rem   (stg_rem[j+1]),
      .dn_quot  (stg_quot[j+1]),
      .dn_pol   (stg_pol[j+1]),
      .dn_err   (stg_err[j+1])
    );
  end

  assign stg_ready[QW] = mac_ready;

  ael_mac #(
    .SW (SW),
    .QW (QW)
  ) u_mac (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .up_valid     (stg_valid[QW]),
    .up_ready     (mac_ready),
    .up_col       (stg_rem[QW][SW-1:0]),
    .up_row       (stg_quot[QW]),
    .up_pol       (stg_pol[QW]),
    .up_err       (stg_err[QW]),
    .dn_valid     (out_valid),
    .dn_ready     (!out_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .polarization (polarization),
    .index_error  (index_error)
  );

endmodule

`default_nettype wire

@@ verif/antenna_element_location_tb.sv @@
// Self-checking testbench for antenna_element_location: element indexes go in, and the x, y, z
// positions, polarization and range flag that come out are compared with a local predictor.
// Depends on ael_pkg and the antenna_element_location RTL.
module antenna_element_location_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ael_pkg::*;

  localparam int MAX_SIDE = 64;
  localparam int PIPE_LATENCY = 3 + $clog2(MAX_SIDE);
  localparam int ITEMS_PER_PHASE = 80;
  localparam int NUM_PHASES = 12;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic                    pol;
    logic                    err;
  } element_pos_t;

  typedef struct {
    logic [IDX_W-1:0] index;
    bit               typed;
    element_pos_t     want;
  } directed_row_t;

  localparam element_pos_t OUT_OF_RANGE = '{23'sd0, 23'sd0, 23'sd0, 1'b0, 1'b1};
  localparam element_pos_t NOT_TYPED = '0;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [IDX_W-1:0] element_index;
  logic out_valid;
  logic out_stall;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic polarization;
  logic index_error;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  antenna_element_location #(
    .MAX_SIDE(MAX_SIDE)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .element_index(element_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .polarization(polarization),
    .index_error(index_error),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cfg_t shadow_cfg = CFG_RESET;
  element_pos_t expected_positions[$];
  int unsigned sender_idle_pct;
  int unsigned receiver_idle_pct;
  int unsigned hold_off_left;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned words_checked;
  int unsigned error_words;
  int unsigned second_pol_words;
  int unsigned settings_used;

  directed_row_t directed_rows[12] = '{
    '{13'd0,    1'b1, '{23'sd0, 23'sd0, 23'sd0, 1'b0, 1'b0}},
    '{13'd15,   1'b1, '{23'sd0, 23'sd3072, 23'sd3072, 1'b0, 1'b0}},
    '{13'd16,   1'b1, OUT_OF_RANGE},
    '{13'd8191, 1'b1, OUT_OF_RANGE},
    '{13'd4096, 1'b1, OUT_OF_RANGE},
    '{13'd1,    1'b0, NOT_TYPED},
    '{13'd4,    1'b0, NOT_TYPED},
    '{13'd5,    1'b0, NOT_TYPED},
    '{13'd10,   1'b0, NOT_TYPED},
    '{13'd12,   1'b0, NOT_TYPED},
    '{13'd3,    1'b0, NOT_TYPED},
    '{13'd2730, 1'b0, NOT_TYPED}
  };

  cfg_t fixed_settings[6] = '{
    '{7'd1,   7'd1,   1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
    '{7'd64,  7'd64,  1'b1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
    '{7'd0,   7'd5,   1'b1, 16'sh0400, 16'sh0400, 16'sh0400, 16'sh0400, 16'sh0400},
    '{7'd7,   7'd0,   1'b0, 16'sh0400, 16'sh0400, 16'sh0400, 16'sh0400, 16'sh0400},
    '{7'd127, 7'd127, 1'b1, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff},
    '{7'd100, 7'd3,   1'b1, 16'shf9c2, 16'sh0b51, 16'sh0213, 16'shfe05, 16'sh07a9}
  };

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned element_count(cfg_t c);
    int unsigned rows;
    int unsigned cols;
    rows = (c.num_rows > MAX_SIDE) ? MAX_SIDE : 32'(c.num_rows);
    cols = (c.num_columns > MAX_SIDE) ? MAX_SIDE : 32'(c.num_columns);
    return c.dual_polarized ? 2 * rows * cols : rows * cols;
  endfunction

  function automatic logic signed [POS_W-1:0] saturate_pos(longint v);
    if (v > POS_MAX) return POS_W'(POS_MAX);
    if (v < POS_MIN) return POS_W'(POS_MIN);
    return POS_W'(v);
  endfunction

  function automatic element_pos_t locate_element(cfg_t c, logic [IDX_W-1:0] idx);
    int unsigned cols;
    int unsigned plane;
    int unsigned folded;
    longint col;
    longint row;
    element_pos_t r;
    cols = (c.num_columns > MAX_SIDE) ? MAX_SIDE : 32'(c.num_columns);
    plane = c.dual_polarized ? element_count(c) / 2 : element_count(c);
    folded = 32'(idx);
    r = '0;
    if (idx >= element_count(c)) begin
      r.err = 1'b1;
      return r;
    end
    if (c.dual_polarized && folded >= plane) begin
      folded = folded - plane;
      r.pol = 1'b1;
    end
    col = folded % cols;
    row = folded / cols;
    r.x = saturate_pos(longint'(c.column_to_x) * col + longint'(c.row_to_x) * row);
    r.y = saturate_pos(longint'(c.column_to_y) * col + longint'(c.row_to_y) * row);
    r.z = saturate_pos(longint'(c.row_to_z) * row);
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(cfg_t c);
    int unsigned cnt;
    int unsigned roll;
    cnt = element_count(c);
    roll = $urandom_range(99);
    if (cnt > 0 && roll < 80) return IDX_W'($urandom_range(cnt - 1, 0));
    if (cnt > 0 && roll < 88) begin
      if (roll[0] || cnt > 8191) return IDX_W'(cnt - 1);
      return IDX_W'(cnt);
    end
    return IDX_W'($urandom);
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.num_rows = ($urandom_range(9) == 0) ? 7'd64 : 7'($urandom_range(8, 1));
    c.num_columns = ($urandom_range(9) == 0) ? 7'd64 : 7'($urandom_range(8, 1));
    c.dual_polarized = 1'($urandom);
    c.column_to_x = 16'($urandom);
    c.column_to_y = 16'($urandom);
    c.row_to_x = 16'($urandom);
    c.row_to_y = 16'($urandom);
    c.row_to_z = 16'($urandom);
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) begin
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  task automatic write_register(reg_idx_t r, logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (r)
      REG_NUM_ROWS:       shadow_cfg.num_rows = d[SIDE_REG_W-1:0];
      REG_NUM_COLUMNS:    shadow_cfg.num_columns = d[SIDE_REG_W-1:0];
      REG_DUAL_POLARIZED: shadow_cfg.dual_polarized = d[0];
      REG_COLUMN_TO_X:    shadow_cfg.column_to_x = d;
      REG_COLUMN_TO_Y:    shadow_cfg.column_to_y = d;
      REG_ROW_TO_X:       shadow_cfg.row_to_x = d;
      REG_ROW_TO_Y:       shadow_cfg.row_to_y = d;
      REG_ROW_TO_Z:       shadow_cfg.row_to_z = d;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(cfg_t c);
    write_register(REG_NUM_ROWS, {9'($urandom), c.num_rows});
    write_register(REG_NUM_COLUMNS, {9'($urandom), c.num_columns});
    write_register(REG_DUAL_POLARIZED, {15'($urandom), c.dual_polarized});
    write_register(REG_COLUMN_TO_X, c.column_to_x);
    write_register(REG_COLUMN_TO_Y, c.column_to_y);
    write_register(REG_ROW_TO_X, c.row_to_x);
    write_register(REG_ROW_TO_Y, c.row_to_y);
    write_register(REG_ROW_TO_Z, c.row_to_z);
    settings_used++;
  endtask

  task automatic offer_index(logic [IDX_W-1:0] idx, bit typed, element_pos_t typed_want);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    element_index <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_positions.push_back(typed ? typed_want : locate_element(shadow_cfg, idx));
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_positions.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_output
    element_pos_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_positions.size() == 0) begin
        report_mismatch("word with nothing expected", pos_x, 0);
      end else begin
        want = expected_positions.pop_front();
        words_checked++;
        if (want.err) error_words++;
        if (want.pol) second_pol_words++;
        if (pos_x !== want.x) report_mismatch("pos_x", pos_x, want.x);
        if (pos_y !== want.y) report_mismatch("pos_y", pos_y, want.y);
        if (pos_z !== want.z) report_mismatch("pos_z", pos_z, want.z);
        if (polarization !== want.pol) report_mismatch("polarization", polarization, want.pol);
        if (index_error !== want.err) report_mismatch("index_error", index_error, want.err);
      end
    end
  end

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_stall <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d words outstanding.",
             cycle_count, expected_positions.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    cfg_t settings;
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    element_index = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_off_left = 0;
    fail_count = 0;
    words_checked = 0;
    error_words = 0;
    second_pol_words = 0;
    settings_used = 0;
    sender_idle_pct = 16;
    receiver_idle_pct = 71;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      offer_index(directed_rows[i].index, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_pipeline();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase == 4) begin
        sender_idle_pct = 71;
        receiver_idle_pct = 16;
      end else if (phase == 8) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
      end
      settings = (phase < 6) ? fixed_settings[phase] : random_settings();
      apply_settings(settings);
      if (phase % 4 == 1) hold_off_left = HOLD_OFF_CYCLES;
      repeat (ITEMS_PER_PHASE) offer_index(pick_index(shadow_cfg), 1'b0, NOT_TYPED);
      drain_pipeline();
    end

    $display("Checked %0d position words under %0d array settings in %0d cycles.",
             words_checked, settings_used + 1, cycle_count);
    $display("Of those, %0d had an out-of-range index and %0d were second polarization.",
             error_words, second_pol_words);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
